// ===== sv/rxhc_pkg.sv =====
// Package for the receive ring header consumer: ring geometry, field widths,
// outcome codes and the per-request decision record.
// No dependencies.
package rxhc_pkg;

  localparam int RING_BYTES       = 8192;
  localparam int ALLOC_BYTES      = 9708;
  localparam int MAX_FRAME_BYTES  = 1536;
  localparam int MIN_HEADER_BYTES = 14;
  localparam int HDR_BYTES        = 4;

  localparam int OFF_W     = $clog2(RING_BYTES);
  localparam int SUM_W     = 18;
  localparam int WORD_W    = 16;
  localparam int OUTCOME_W = 2;
  localparam int COPY_W    = 11;
  localparam int START_W   = 14;
  localparam int HADDR_W   = 13;

  localparam logic [WORD_W-1:0] BUSY_MARK = 16'hFFF0;
  localparam logic [WORD_W-1:0] RP_BACK   = 16'd16;

  localparam logic [OUTCOME_W-1:0] OUT_IDLE    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_RESET   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DELIVER = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_DROP    = 2'd3;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [COPY_W-1:0]    copy_length;
    logic [START_W-1:0]   data_start;
    logic [OFF_W-1:0]     off_nxt;
    logic [WORD_W-1:0]    rp_nxt;
  } decide_t;

endpackage

// ===== sv/rxhc_decide.sv =====
// Header decision for one pop request: classifies the header at the current
// read offset and computes the next offset and read-pointer value.
// Depends on rxhc_pkg.
module rxhc_decide (
  input  logic                                     ring_empty,
  input  logic [rxhc_pkg::WORD_W-1:0]              header_status,
  input  logic [rxhc_pkg::WORD_W-1:0]              header_length,
  input  logic [rxhc_pkg::WORD_W-1:0]              buffer_limit,
  input  logic [rxhc_pkg::OFF_W-1:0]               off,
  input  logic [rxhc_pkg::WORD_W-1:0]              rp,
  output rxhc_pkg::decide_t                        dec
);

  localparam logic [rxhc_pkg::SUM_W-1:0] ALLOC_S =
    rxhc_pkg::SUM_W'(rxhc_pkg::ALLOC_BYTES);
  localparam logic [rxhc_pkg::SUM_W-1:0] HDR_S = rxhc_pkg::SUM_W'(rxhc_pkg::HDR_BYTES);
  localparam logic [rxhc_pkg::WORD_W-1:0] LEN_MIN =
    rxhc_pkg::WORD_W'(rxhc_pkg::HDR_BYTES + rxhc_pkg::MIN_HEADER_BYTES);
  localparam logic [rxhc_pkg::WORD_W-1:0] LEN_MAX =
    rxhc_pkg::WORD_W'(rxhc_pkg::MAX_FRAME_BYTES);

  logic [rxhc_pkg::SUM_W-1:0]  off_s;
  logic [rxhc_pkg::SUM_W-1:0]  len_s;
  logic [rxhc_pkg::SUM_W-1:0]  start_s;
  logic [rxhc_pkg::SUM_W-1:0]  adv_s;
  logic [rxhc_pkg::OFF_W-1:0]  new_off;
  logic [rxhc_pkg::WORD_W-1:0] pkt;
  logic [rxhc_pkg::WORD_W-1:0] copy_w;
  logic                        past_alloc;
  logic                        bogus;
  logic                        good;

  assign off_s      = rxhc_pkg::SUM_W'(off);
  assign len_s      = rxhc_pkg::SUM_W'(header_length);
  assign start_s    = off_s + HDR_S;
  assign past_alloc = start_s > ALLOC_S;
  assign bogus      = (header_length < LEN_MIN) || (header_length > LEN_MAX) ||
                      ((start_s + len_s) > ALLOC_S);
  // skip header and frame, round up to a 4-byte boundary, wrap on ring size
  assign adv_s      = start_s + len_s + rxhc_pkg::SUM_W'(3);
  assign new_off    = {adv_s[rxhc_pkg::OFF_W-1:2], 2'b00};
  assign pkt        = header_length - rxhc_pkg::WORD_W'(rxhc_pkg::HDR_BYTES);
  assign copy_w     = (pkt < buffer_limit) ? pkt : buffer_limit;
  assign good       = header_status[0] && (header_status[5:1] == 5'd0);

  always_comb begin
    dec.outcome     = rxhc_pkg::OUT_IDLE;
    dec.copy_length = '0;
    dec.data_start  = '0;
    dec.off_nxt     = off;
    dec.rp_nxt      = rp;
    if (ring_empty) begin
      dec.outcome = rxhc_pkg::OUT_IDLE;
    end else if (past_alloc) begin
      dec.outcome = rxhc_pkg::OUT_RESET;
      dec.off_nxt = '0;
      dec.rp_nxt  = rxhc_pkg::BUSY_MARK;
    end else if (header_length == rxhc_pkg::BUSY_MARK) begin
      dec.outcome = rxhc_pkg::OUT_IDLE;
    end else if (bogus) begin
      dec.outcome = rxhc_pkg::OUT_RESET;
      dec.off_nxt = '0;
      dec.rp_nxt  = rxhc_pkg::BUSY_MARK;
    end else begin
      dec.data_start = start_s[rxhc_pkg::START_W-1:0];
      if (good) begin
        dec.outcome     = rxhc_pkg::OUT_DELIVER;
        dec.copy_length = copy_w[rxhc_pkg::COPY_W-1:0];
      end else begin
        dec.outcome = rxhc_pkg::OUT_DROP;
      end
      dec.off_nxt = new_off;
      dec.rp_nxt  = rxhc_pkg::WORD_W'(new_off) - rxhc_pkg::RP_BACK;
    end
  end

endmodule

// ===== sv/rx_ring_header_consumer_unit.sv =====
// Top level of the receive ring header consumer: input register, header
// decision, result register and ring state (read offset, read pointer).
// Depends on rxhc_pkg and rxhc_decide.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | ring_empty, header_status, header_length,
//          |           |                    | buffer_limit
//  out_    | output    | out_valid/out_stall | outcome, copy_length, data_start,
//          |           |                    | header_address, read_pointer_value
//
// One request per cycle while in_stall is low; each request passes the input register, then the result register.
// The read offset is updated in the same cycle the result is registered, so
// back-to-back requests see the offset left by the previous one.
// Synchronous active-low reset: offset 0, read pointer 0xFFF0, pipeline empty.
// out_stall holds the result register; in_stall rises only when both stages
// are full and the output is stalled.
module rx_ring_header_consumer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_ring_empty,
  input  logic [rxhc_pkg::WORD_W-1:0]        in_header_status,
  input  logic [rxhc_pkg::WORD_W-1:0]        in_header_length,
  input  logic [rxhc_pkg::WORD_W-1:0]        in_buffer_limit,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rxhc_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [rxhc_pkg::COPY_W-1:0]        out_copy_length,
  output logic [rxhc_pkg::START_W-1:0]       out_data_start,
  output logic [rxhc_pkg::HADDR_W-1:0]       out_header_address,
  output logic [rxhc_pkg::WORD_W-1:0]        out_read_pointer_value
);

  logic                               in_valid_r;
  logic                               empty_r;
  logic [rxhc_pkg::WORD_W-1:0]        status_r;
  logic [rxhc_pkg::WORD_W-1:0]        length_r;
  logic [rxhc_pkg::WORD_W-1:0]        limit_r;
  logic [rxhc_pkg::OFF_W-1:0]         off_r;
  logic [rxhc_pkg::WORD_W-1:0]        rp_r;
  logic                               out_valid_r;
  logic [rxhc_pkg::OUTCOME_W-1:0]     outcome_r;
  logic [rxhc_pkg::COPY_W-1:0]        copy_r;
  logic [rxhc_pkg::START_W-1:0]       start_r;
  logic [rxhc_pkg::HADDR_W-1:0]       haddr_r;
  logic [rxhc_pkg::WORD_W-1:0]        rpv_r;
  logic                               s1_adv;
  logic                               in_take;
  rxhc_pkg::decide_t                  dec;

  assign s1_adv   = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  rxhc_decide u_decide (
    .ring_empty    (empty_r),
    .header_status (status_r),
    .header_length (length_r),
    .buffer_limit  (limit_r),
    .off           (off_r),
    .rp            (rp_r),
    .dec           (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      off_r       <= '0;
      rp_r        <= rxhc_pkg::BUSY_MARK;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (s1_adv) begin
        in_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        off_r       <= dec.off_nxt;
        rp_r        <= dec.rp_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      empty_r  <= in_ring_empty;
      status_r <= in_header_status;
      length_r <= in_header_length;
      limit_r  <= in_buffer_limit;
    end
    if (s1_adv) begin
      outcome_r <= dec.outcome;
      copy_r    <= dec.copy_length;
      start_r   <= dec.data_start;
      haddr_r   <= rxhc_pkg::HADDR_W'(dec.off_nxt);
      rpv_r     <= dec.rp_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_outcome            = outcome_r;
  assign out_copy_length        = copy_r;
  assign out_data_start         = start_r;
  assign out_header_address     = haddr_r;
  assign out_read_pointer_value = rpv_r;

  // read pointer always trails the offset by 16
  a_rp_tracks_off: assert property (@(posedge clk) disable iff (!rst_n)
    rp_r == (rxhc_pkg::WORD_W'(off_r) - rxhc_pkg::RP_BACK))
    else $error("read pointer out of step with offset");

  a_off_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    off_r[1:0] == 2'b00)
    else $error("read offset not 4-aligned");

  a_copy_only_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (outcome_r != rxhc_pkg::OUT_DELIVER) |-> copy_r == '0)
    else $error("copy length set on non-delivered frame");

  a_reset_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (outcome_r == rxhc_pkg::OUT_RESET) |->
      (haddr_r == '0) && (rpv_r == rxhc_pkg::BUSY_MARK) && (start_r == '0))
    else $error("ring reset outcome with stale state");

  a_hold_state_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(off_r))
    else $error("offset moved without a request");

endmodule
